/* sv/vps_pkg.sv */
// package for the voice packetiser and scrambler
// widths, register indexes, reset values and the scramble function; no dependencies
package vps_pkg;

	localparam int MIC_W       = 12;
	localparam int SAMPLE_W    = 8;
	localparam int THR_W       = 8;
	localparam int LIMIT_W     = 16;
	localparam int KEY_W       = 8;
	localparam int RUN_W       = 16;
	localparam int POS_W       = 6;
	localparam int LEN_W       = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int PACKET_BYTES_DEF = 64;

	localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd50;
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = 16'd100;
	localparam logic [KEY_W-1:0]   KEY_RST       = 8'hA5;
	localparam logic [RUN_W-1:0]   RUN_MAX       = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SILENCE_THRESHOLD = 2'd0,
		REG_SILENCE_LIMIT     = 2'd1,
		REG_SCRAMBLE_KEY      = 2'd2
	} reg_idx_t;

	// release notice from the back end: a bank has had its last byte read
	typedef struct packed {
		logic valid;
		logic bank;
	} vps_done_t;

	function automatic int count_w(input int p);
		return $clog2(p + 1);
	endfunction

	function automatic int index_w(input int p);
		return (p > 1) ? $clog2(p) : 1;
	endfunction

	// xor with key^index, then rotate left by one
	function automatic logic [SAMPLE_W-1:0] scramble(input logic [SAMPLE_W-1:0] b,
			input logic [KEY_W-1:0] key, input logic [SAMPLE_W-1:0] idx);
		logic [SAMPLE_W-1:0] x;
		x = b ^ key ^ idx;
		return {x[SAMPLE_W-2:0], x[SAMPLE_W-1]};
	endfunction

endpackage

/* sv/vps_sample_if.sv */
// sample channel interface: one microphone reading and the talk level
// depends on vps_pkg
interface vps_sample_if;
	logic                          valid;
	logic                          ready;
	logic [vps_pkg::MIC_W-1:0]     mic_reading;
	logic                          talk_active;

	modport source(output valid, mic_reading, talk_active, input ready);
	modport sink(input valid, mic_reading, talk_active, output ready);
endinterface

/* sv/vps_byte_if.sv */
// output channel interface: one scrambled byte with its packet position
// depends on vps_pkg
interface vps_byte_if;
	logic                          valid;
	logic                          ready;
	logic [vps_pkg::SAMPLE_W-1:0]  scrambled_byte;
	logic [vps_pkg::POS_W-1:0]     byte_position;
	logic [vps_pkg::LEN_W-1:0]     packet_length;
	logic                          last_byte;

	modport source(output valid, scrambled_byte, byte_position, packet_length, last_byte,
		input ready);
	modport sink(input valid, scrambled_byte, byte_position, packet_length, last_byte,
		output ready);
endinterface

/* sv/vps_cfg_if.sv */
// configuration write channel interface: register index and write data
// depends on vps_pkg
interface vps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vps_pkg::CFG_IDX_W-1:0]   index;
	logic [vps_pkg::CFG_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* sv/vps_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module vps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/vps_front.sv */
// front end: takes samples, fills the current bank, tracks the silent run
// and queues a flush command per packet; depends on vps_pkg
module vps_front #(
	parameter int PACKET_BYTES = vps_pkg::PACKET_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [vps_pkg::MIC_W-1:0]              mic_reading,
	input  logic                                   talk_active,
	input  logic [vps_pkg::THR_W-1:0]              threshold,
	input  logic [vps_pkg::LIMIT_W-1:0]            limit,
	output logic                                   wr_en,
	output logic [vps_pkg::index_w(PACKET_BYTES):0] wr_addr,
	output logic [vps_pkg::SAMPLE_W-1:0]           wr_data,
	output logic                                   cmd_push,
	output logic [vps_pkg::count_w(PACKET_BYTES):0] cmd_data,
	input  vps_pkg::vps_done_t                     done
);
	import vps_pkg::*;

	localparam int CW = count_w(PACKET_BYTES);
	localparam int IW = index_w(PACKET_BYTES);

	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       fill_inc;
	logic [RUN_W-1:0]    run_q;
	logic [RUN_W-1:0]    run_nx;
	logic                bank_q;
	logic [1:0]          busy_q;
	logic [1:0]          busy_nx;
	logic [SAMPLE_W-1:0] sample;
	logic                store_ok;
	logic                flush;
	logic                accept;

	assign sample   = mic_reading[MIC_W-1 -: SAMPLE_W];
	assign in_ready = !busy_q[bank_q];
	assign accept   = in_valid && in_ready;
	assign store_ok = fill_q < CW'(PACKET_BYTES);
	assign fill_inc = store_ok ? fill_q + CW'(1) : fill_q;

	always_comb begin
		if (sample < threshold) begin
			run_nx = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
		end else begin
			run_nx = '0;
		end
	end

	assign flush = talk_active && ((fill_inc == CW'(PACKET_BYTES)) || (run_nx > limit));

	assign wr_en    = accept && talk_active && store_ok;
	assign wr_addr  = {bank_q, fill_q[IW-1:0]};
	assign wr_data  = sample;
	assign cmd_push = accept && flush;
	assign cmd_data = {bank_q, fill_inc};

	always_comb begin
		busy_nx = busy_q;
		if (done.valid) begin
			busy_nx[done.bank] = 1'b0;
		end
		if (cmd_push) begin
			busy_nx[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			run_q  <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_nx;
			if (accept) begin
				if (!talk_active) begin
					fill_q <= '0;
					run_q  <= '0;
				end else begin
					run_q  <= run_nx;
					fill_q <= flush ? '0 : fill_inc;
					if (flush) begin
						bank_q <= !bank_q;
					end
				end
			end
		end
	end

endmodule

/* sv/vps_cmd_fifo.sv */
// two-entry command queue between front and back end
// no dependencies
module vps_cmd_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/vps_back.sv */
// back end: drains one queued packet a byte a cycle from the store while the output does not stall, and scrambles it
// depends on vps_pkg
module vps_back #(
	parameter int PACKET_BYTES = vps_pkg::PACKET_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_empty,
	input  logic [vps_pkg::count_w(PACKET_BYTES):0] cmd_data,
	output logic                                   cmd_pop,
	output logic                                   rd_en,
	output logic [vps_pkg::index_w(PACKET_BYTES):0] rd_addr,
	input  logic [vps_pkg::SAMPLE_W-1:0]           rd_data,
	input  logic [vps_pkg::KEY_W-1:0]              key,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [vps_pkg::SAMPLE_W-1:0]           scrambled_byte,
	output logic [vps_pkg::POS_W-1:0]              byte_position,
	output logic [vps_pkg::LEN_W-1:0]              packet_length,
	output logic                                   last_byte,
	output vps_pkg::vps_done_t                     done
);
	import vps_pkg::*;

	localparam int CW = count_w(PACKET_BYTES);
	localparam int IW = index_w(PACKET_BYTES);

	logic          act_q;
	logic          bank_q;
	logic [CW-1:0] len_q;
	logic [IW-1:0] idx_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic [CW-1:0] len_s1;
	logic          last_s1;
	logic          last_c;
	logic          adv;
	logic          issue;

	assign cmd_pop = !act_q && !cmd_empty;
	assign last_c  = (CW'(idx_q) + CW'(1)) == len_q;
	// the read data register holds while the output stalls
	assign adv     = !valid_s1 || out_ready;
	assign issue   = adv && act_q;

	assign rd_en   = issue;
	assign rd_addr = {bank_q, idx_q};

	assign done.valid = issue && last_c;
	assign done.bank  = bank_q;

	assign out_valid      = valid_s1;
	assign scrambled_byte = scramble(rd_data, key, SAMPLE_W'(idx_s1));
	assign byte_position  = POS_W'(idx_s1);
	assign packet_length  = LEN_W'(len_s1);
	assign last_byte      = last_s1;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			bank_q <= cmd_data[CW];
			len_q  <= cmd_data[CW-1:0];
		end
		if (issue) begin
			idx_s1  <= idx_q;
			len_s1  <= len_q;
			last_s1 <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= act_q;
			end
			if (cmd_pop) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + IW'(1);
				if (last_c) begin
					act_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* sv/voice_packetizer_scrambler_unit.sv */
// top level of the voice packetiser and scrambler: config registers, front end,
// command queue, two-bank sample store and back end; depends on vps_pkg and all vps modules
//
// channel   | role   | transaction
// ----------+--------+-----------------------------------------------------------
// cfg       | sink   | one register write: index, data (ready is always high)
// samples   | sink   | one sample tick: mic_reading, talk_active
// tx_bytes  | source | one scrambled byte: byte, position, packet length, last mark
//
// a sample is taken while the bank it fills is free; the store has two
// banks so a new packet fills while the previous one drains
// a flushed packet of n bytes drains one byte a cycle while tx_bytes does not stall; its first byte
// follows the flushing sample via queue write, queue pop and store read; the single store read port sets the rate
// samples stall only when both banks still hold packets not yet read out
// a stall on tx_bytes holds the current byte and stops store reads, nothing else
// reset clears counts, bank flags and the queue; the store itself needs no clearing
module voice_packetizer_scrambler_unit #(
	parameter int PACKET_BYTES = vps_pkg::PACKET_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	vps_cfg_if.sink      cfg,
	vps_sample_if.sink   samples,
	vps_byte_if.source   tx_bytes
);
	import vps_pkg::*;

	localparam int CW = count_w(PACKET_BYTES);
	localparam int IW = index_w(PACKET_BYTES);
	// bank bit on top of the in-packet index
	localparam int AW = IW + 1;
	localparam int RAM_DEPTH = 2 ** AW;

	// configuration registers
	logic [THR_W-1:0]   threshold_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [KEY_W-1:0]   key_q;

	// store ports
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [SAMPLE_W-1:0] rd_data;

	// command queue: {bank, packet length}
	logic          cmd_push;
	logic [CW:0]   cmd_push_data;
	logic          cmd_pop;
	logic          cmd_empty;
	logic [CW:0]   cmd_pop_data;

	// bank release from the back end
	vps_done_t     done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			limit_q     <= LIMIT_RST;
			key_q       <= KEY_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SILENCE_THRESHOLD: threshold_q <= cfg.data[THR_W-1:0];
				REG_SILENCE_LIMIT:     limit_q     <= cfg.data[LIMIT_W-1:0];
				REG_SCRAMBLE_KEY:      key_q       <= cfg.data[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	// front end: fill and flush decision
	vps_front #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (samples.valid),
		.in_ready    (samples.ready),
		.mic_reading (samples.mic_reading),
		.talk_active (samples.talk_active),
		.threshold   (threshold_q),
		.limit       (limit_q),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_push_data),
		.done        (done)
	);

	// at most two packets are outstanding, one per bank, so the queue never overflows
	vps_cmd_fifo #(
		.WIDTH(CW + 1)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_push_data),
		.pop       (cmd_pop),
		.empty     (cmd_empty),
		.pop_data  (cmd_pop_data)
	);

	// two-bank sample store
	vps_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// back end: drain and scramble
	vps_back #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (cmd_empty),
		.cmd_data       (cmd_pop_data),
		.cmd_pop        (cmd_pop),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.key            (key_q),
		.out_valid      (tx_bytes.valid),
		.out_ready      (tx_bytes.ready),
		.scrambled_byte (tx_bytes.scrambled_byte),
		.byte_position  (tx_bytes.byte_position),
		.packet_length  (tx_bytes.packet_length),
		.last_byte      (tx_bytes.last_byte),
		.done           (done)
	);

endmodule
